// ===== rtl/core/fwt_pkg.sv =====
`default_nettype none

package fwt_pkg;

  // Field widths
  localparam int IDX_W  = 11;
  localparam int DATA_W = 32;
  // Walk pointer: wide enough for a node index plus its lowest set bit
  localparam int PTR_W  = IDX_W + 1;

  localparam int MAX_POSITIONS_DEF = 1024;
  localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

  // Command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_PREFIX = 2'd1;
  localparam logic [1:0] CMD_RANGE  = 2'd2;
  localparam logic [1:0] CMD_LBOUND = 2'd3;

  // Datapath operations issued by the controller
  typedef logic [3:0] dp_op_t;
  localparam dp_op_t DP_NOP        = 4'd0;
  localparam dp_op_t DP_LOAD       = 4'd1;
  localparam dp_op_t DP_CLEAR      = 4'd2;
  localparam dp_op_t DP_READ_X     = 4'd3;
  localparam dp_op_t DP_ADD_WRITE  = 4'd4;
  localparam dp_op_t DP_SUM_ACC    = 4'd5;
  localparam dp_op_t DP_SECOND     = 4'd6;
  localparam dp_op_t DP_READ_PROBE = 4'd7;
  localparam dp_op_t DP_LB_CMP     = 4'd8;
  localparam dp_op_t DP_LB_SKIP    = 4'd9;
  localparam dp_op_t DP_FINISH     = 4'd10;

  // Status returned by the datapath
  typedef struct packed {
    logic [1:0] cmd;
    logic       x_zero;
    logic       x_over;
    logic       k_zero;
    logic       probe_ok;
    logic       target_nonpos;
    logic       second;
    logic       clr_last;
  } dp_status_t;

  // Lowest set bit of a pointer
  function automatic logic [PTR_W-1:0] low_bit(input logic [PTR_W-1:0] x);
    low_bit = x & (~x + PTR_W'(1));
  endfunction

  // Smallest power of two not below n, and 1 for n of 0 or 1
  function automatic logic [PTR_W-1:0] ceil_pow2(input logic [IDX_W-1:0] n);
    logic [IDX_W-1:0] m;
    logic [PTR_W-1:0] r;
    m = n - IDX_W'(1);
    r = PTR_W'(1);
    if (n > IDX_W'(1)) begin
      for (int i = 0; i < IDX_W; i++) begin
        if (m[i]) r = PTR_W'(2) << i;
      end
    end
    ceil_pow2 = r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fenwick_tree_prefix_sum.sv =====
`default_nettype none
// Channel   Ports                                      Handshake
// item in   command, index, index_end, value           start & !busy
// result    total, position                            result_valid, one cycle
// config    cfg_data (size_in_use)                     cfg_valid & cfg_ready
//
// After reset the node store is swept to zero, one node a cycle, with busy
// high throughout. Configuration writes are taken at any time.
// Each item walks the tree one node at a time: each visited node is read,
// then updated (add) or accumulated (sums), since the node memory read is
// registered; a range sum walks twice. Lower bound reads and compares each
// probed node and skips each level whose probe lies beyond the size.
// Results cannot be held off; an add gives no result.

module fenwick_tree_prefix_sum
  import fwt_pkg::*;
#(
  parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               command,
  input  wire logic [IDX_W-1:0]         index,
  input  wire logic [IDX_W-1:0]         index_end,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          result_valid,
  output logic signed [DATA_W-1:0]      total,
  output logic [IDX_W-1:0]              position,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [IDX_W-1:0]         cfg_data
);

  dp_status_t status;
  dp_op_t     op;

  assign cfg_ready = 1'b1;

  fwt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .op     (op)
  );

  fwt_dp #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .command      (command),
    .index        (index),
    .index_end    (index_end),
    .value        (value),
    .op           (op),
    .status       (status),
    .result_valid (result_valid),
    .total        (total),
    .position     (position)
  );

  // Result strobe lasts a single cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  // An accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after taking an item");

  // A result only follows work in progress
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without an item in progress");

  // A lower bound result carries no total
  a_lbound_total: assert property (@(posedge clk) disable iff (rst)
    (result_valid && position != '0) |-> (total == '0))
    else $error("position and total both set");

endmodule

`default_nettype wire

// ===== rtl/core/fwt_ctrl.sv =====
`default_nettype none

module fwt_ctrl
  import fwt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire dp_status_t status,
  output dp_op_t          op
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_ADD_RD   = 4'd3;
  localparam logic [3:0] S_ADD_WR   = 4'd4;
  localparam logic [3:0] S_SUM_RD   = 4'd5;
  localparam logic [3:0] S_SUM_ACC  = 4'd6;
  localparam logic [3:0] S_LB_PROBE = 4'd7;
  localparam logic [3:0] S_LB_CMP   = 4'd8;
  localparam logic [3:0] S_FINISH   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign busy = (state != S_IDLE);

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Pick the next state and the datapath operation
  always_comb begin
    state_next = state;
    op         = DP_NOP;
    case (state)
      S_CLEAR: begin
        op = DP_CLEAR;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          op         = DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.cmd)
          CMD_ADD:    state_next = S_ADD_RD;
          CMD_PREFIX: state_next = S_SUM_RD;
          CMD_RANGE:  state_next = S_SUM_RD;
          default:    state_next = status.target_nonpos ? S_FINISH : S_LB_PROBE;
        endcase
      end
      S_ADD_RD: begin
        if (status.x_zero || status.x_over) begin
          state_next = S_IDLE;
        end else begin
          op         = DP_READ_X;
          state_next = S_ADD_WR;
        end
      end
      S_ADD_WR: begin
        op         = DP_ADD_WRITE;
        state_next = S_ADD_RD;
      end
      S_SUM_RD: begin
        if (!status.x_zero) begin
          op         = DP_READ_X;
          state_next = S_SUM_ACC;
        end else if (status.cmd == CMD_RANGE && !status.second) begin
          op = DP_SECOND;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SUM_ACC: begin
        op         = DP_SUM_ACC;
        state_next = S_SUM_RD;
      end
      S_LB_PROBE: begin
        if (status.k_zero) begin
          state_next = S_FINISH;
        end else if (status.probe_ok) begin
          op         = DP_READ_PROBE;
          state_next = S_LB_CMP;
        end else begin
          op = DP_LB_SKIP;
        end
      end
      S_LB_CMP: begin
        op         = DP_LB_CMP;
        state_next = S_LB_PROBE;
      end
      S_FINISH: begin
        op         = DP_FINISH;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/fwt_dp.sv =====
`default_nettype none

module fwt_dp
  import fwt_pkg::*;
#(
  parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_valid,
  input  wire logic [IDX_W-1:0]         cfg_data,
  input  wire logic [1:0]               command,
  input  wire logic [IDX_W-1:0]         index,
  input  wire logic [IDX_W-1:0]         index_end,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire dp_op_t                   op,
  output dp_status_t                    status,
  output logic                          result_valid,
  output logic signed [DATA_W-1:0]      total,
  output logic [IDX_W-1:0]              position
);

  localparam int AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;

  logic [IDX_W-1:0]  size_in_use;
  logic [IDX_W-1:0]  n_eff;
  logic [IDX_W-1:0]  n;
  logic [1:0]        cmd;
  logic [IDX_W-1:0]  idx;
  logic [DATA_W-1:0] w;
  logic [DATA_W-1:0] acc;
  logic [PTR_W-1:0]  x;
  logic [PTR_W-1:0]  k;
  logic              second;
  logic              lb_zero;
  logic [AW-1:0]     clr_addr;

  logic [DATA_W-1:0] mem [MAX_POSITIONS];
  logic [DATA_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              wr_en;

  logic [PTR_W-1:0]  x_dec;
  logic [PTR_W-1:0]  probe;
  logic [PTR_W-1:0]  probe_dec;
  logic [PTR_W-1:0]  n_ext;
  logic [IDX_W-1:0]  idx_clamp;
  logic [IDX_W-1:0]  iend_clamp;

  // Size register, written whenever the config channel offers data
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
    end else if (cfg_valid) begin
      size_in_use <= cfg_data;
    end
  end

  // Effective size: the register limited to the node count
  always_comb begin
    n_eff = size_in_use;
    if (32'(size_in_use) > 32'(MAX_POSITIONS)) n_eff = IDX_W'(MAX_POSITIONS);
  end

  assign n_ext      = PTR_W'(n);
  assign x_dec      = x - PTR_W'(1);
  assign probe      = x + k;
  assign probe_dec  = probe - PTR_W'(1);
  assign idx_clamp  = (index > n_eff) ? n_eff : index;
  assign iend_clamp = (index_end > n_eff) ? n_eff : index_end;

  // Node store: one write port, one registered read port
  assign rd_addr = (op == DP_READ_PROBE) ? AW'(probe_dec) : AW'(x_dec);
  assign wr_en   = (op == DP_CLEAR) || (op == DP_ADD_WRITE);
  assign wr_addr = (op == DP_CLEAR) ? clr_addr : AW'(x_dec);
  assign wr_data = (op == DP_CLEAR) ? '0 : (rd_data + w);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // Clearing sweep pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (op == DP_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    case (op)
      DP_LOAD: begin
        cmd     <= command;
        idx     <= idx_clamp;
        w       <= value;
        n       <= n_eff;
        acc     <= '0;
        second  <= 1'b0;
        lb_zero <= (value <= 0);
        k       <= ceil_pow2(n_eff);
        case (command)
          CMD_ADD:    x <= PTR_W'(index);
          CMD_PREFIX: x <= PTR_W'(idx_clamp);
          CMD_RANGE:  x <= PTR_W'(iend_clamp);
          default:    x <= '0;
        endcase
      end
      DP_ADD_WRITE: begin
        x <= x + low_bit(x);
      end
      DP_SUM_ACC: begin
        acc <= second ? (acc - rd_data) : (acc + rd_data);
        x   <= x - low_bit(x);
      end
      DP_SECOND: begin
        second <= 1'b1;
        x      <= PTR_W'(idx);
      end
      DP_LB_CMP: begin
        if ($signed(rd_data) < $signed(w)) begin
          w <= w - rd_data;
          x <= probe;
        end
        k <= k >> 1;
      end
      DP_LB_SKIP: begin
        k <= k >> 1;
      end
      default: begin
      end
    endcase
  end

  // Result registers and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (op == DP_FINISH);
    end
  end

  // Lower bound gives position 0 only when the original target was at most zero; sums give 0
  always_ff @(posedge clk) begin
    if (op == DP_FINISH) begin
      if (cmd == CMD_LBOUND) begin
        total    <= '0;
        position <= lb_zero ? '0 : IDX_W'(x + PTR_W'(1));
      end else begin
        total    <= acc;
        position <= '0;
      end
    end
  end

  // Status back to the controller
  always_comb begin
    status.cmd           = cmd;
    status.x_zero        = (x == '0);
    status.x_over        = (x > n_ext);
    status.k_zero        = (k == '0);
    status.probe_ok      = (probe <= n_ext);
    status.target_nonpos = ($signed(w) <= 0);
    status.second        = second;
    status.clr_last      = (32'(clr_addr) == 32'(MAX_POSITIONS - 1));
  end

endmodule

`default_nettype wire
